// File: rtl/cmt_pkg.sv
// Shared types, register codes and constants for the compare-match timer channel.
package cmt_pkg;

  localparam int COUNTER_WIDTH = 16;
  // Compares and subtractions run at the wider of the counter and the 16-bit compare registers.
  localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [3:0] REG_CONTROL = 4'd0;
  localparam logic [3:0] REG_MODE    = 4'd1;
  localparam logic [3:0] REG_IO      = 4'd2;
  localparam logic [3:0] REG_INT_EN  = 4'd3;
  localparam logic [3:0] REG_STATUS  = 4'd4;
  localparam logic [3:0] REG_COUNT   = 4'd5;
  localparam logic [3:0] REG_CMP_A   = 4'd6;
  localparam logic [3:0] REG_CMP_B   = 4'd7;
  localparam logic [3:0] REG_CAPTURE = 4'd8;

  localparam logic [7:0] CLEAR_MODE_MASK = 8'hE0;
  localparam logic [7:0] CLEAR_BY_A      = 8'h20;
  localparam logic [7:0] CLEAR_BY_B      = 8'h40;
  localparam logic [7:0] STATUS_RESET    = 8'hC0;
  localparam logic [15:0] COMPARE_RESET  = 16'hFFFF;

  localparam logic [2:0] DIV_SEL_4  = 3'd1;
  localparam logic [2:0] DIV_SEL_16 = 3'd2;
  localparam logic [2:0] DIV_SEL_64 = 3'd3;

  typedef logic [COUNTER_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  reg_sel;
    logic        size_is_word;
    logic [15:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  control;
    logic [7:0]  int_enable;
    logic [7:0]  status;
    count_t      count;
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [5:0]  prescale;
  } tick_state_t;

  typedef struct packed {
    logic [7:0] status;
    count_t     count;
    logic [5:0] prescale;
    logic       irq_a;
    logic       irq_b;
  } tick_res_t;

  function automatic logic [6:0] divisor(input logic [2:0] sel);
    logic [6:0] d;
    case (sel)
      DIV_SEL_4:  d = 7'd4;
      DIV_SEL_16: d = 7'd16;
      DIV_SEL_64: d = 7'd64;
      default:    d = 7'd1;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/cmt_tick.sv
// Next-state logic for one input-clock tick: prescaler, counter and both compare matches.
module cmt_tick (
  input  cmt_pkg::tick_state_t st,
  output cmt_pkg::tick_res_t   res
);
  import cmt_pkg::*;

  logic [6:0]  presc_inc;
  logic        wrap;
  count_t      count1;
  count_t      count2;
  count_t      count3;
  count_t      cmp_a_c;
  count_t      cmp_b_c;
  logic        match_a;
  logic        match_b;
  logic [7:0]  status1;
  logic [7:0]  status2;

  assign presc_inc = {1'b0, st.prescale} + 7'd1;
  // A prescale count left above a smaller new divisor still wraps here.
  assign wrap      = presc_inc >= divisor(st.control[2:0]);
  assign count1    = wrap ? count_t'(st.count + count_t'(1)) : st.count;

  assign cmp_a_c = count_t'(CMP_W'(st.cmp_a));
  assign cmp_b_c = count_t'(CMP_W'(st.cmp_b));

  assign match_a = CMP_W'(count1) >= CMP_W'(st.cmp_a);
  assign count2  = (match_a && ((st.control & CLEAR_MODE_MASK) == CLEAR_BY_A)) ?
                   count_t'(count1 - cmp_a_c) : count1;
  assign status1 = (match_a && st.int_enable[0]) ? (st.status | 8'h01) : st.status;

  // Compare B sees the counter after any compare-A pull-back.
  assign match_b = CMP_W'(count2) >= CMP_W'(st.cmp_b);
  assign count3  = (match_b && ((st.control & CLEAR_MODE_MASK) == CLEAR_BY_B)) ?
                   count_t'(count2 - cmp_b_c) : count2;
  assign status2 = (match_b && st.int_enable[1]) ? (status1 | 8'h02) : status1;

  assign res.prescale = wrap ? 6'd0 : presc_inc[5:0];
  assign res.count    = count3;
  assign res.status   = status2;
  assign res.irq_a    = match_a && st.int_enable[0];
  assign res.irq_b    = match_b && st.int_enable[1];

endmodule

// File: rtl/cmt_core.sv
// Timer register file: register reads and writes, and state update on each committed beat.
module cmt_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          commit,
  input  cmt_pkg::req_t req,
  output logic [15:0]   read_data,
  output logic          irq_a,
  output logic          irq_b
);
  import cmt_pkg::*;

  logic [7:0]  control_r;
  logic [7:0]  mode_r;
  logic [7:0]  io_control_r;
  logic [7:0]  int_enable_r;
  logic [7:0]  status_r;
  count_t      count_r;
  logic [15:0] cmp_a_r;
  logic [15:0] cmp_b_r;
  logic [7:0]  capture_r;
  logic [5:0]  prescale_r;

  tick_state_t tst;
  tick_res_t   tres;
  logic [15:0] wdata;
  logic [15:0] rd_raw;
  logic [CMP_W-1:0] count_ext;
  logic        is_write;
  logic        is_tick;

  assign tst.control    = control_r;
  assign tst.int_enable = int_enable_r;
  assign tst.status     = status_r;
  assign tst.count      = count_r;
  assign tst.cmp_a      = cmp_a_r;
  assign tst.cmp_b      = cmp_b_r;
  assign tst.prescale   = prescale_r;

  cmt_tick u_tick (
    .st  (tst),
    .res (tres)
  );

  assign wdata     = req.size_is_word ? req.write_data : {8'h00, req.write_data[7:0]};
  assign count_ext = CMP_W'(count_r);
  assign is_write  = commit && (req.req_type == REQ_WRITE);
  assign is_tick   = commit && (req.req_type == REQ_TICK);

  always_comb begin
    unique case (req.reg_sel)
      REG_CONTROL: rd_raw = {8'h00, control_r};
      REG_MODE:    rd_raw = {8'h00, mode_r};
      REG_IO:      rd_raw = {8'h00, io_control_r};
      REG_INT_EN:  rd_raw = {8'h00, int_enable_r};
      REG_STATUS:  rd_raw = {8'h00, status_r};
      REG_COUNT:   rd_raw = count_ext[15:0];
      REG_CMP_A:   rd_raw = cmp_a_r;
      REG_CMP_B:   rd_raw = cmp_b_r;
      REG_CAPTURE: rd_raw = {8'h00, capture_r};
      default:     rd_raw = 16'h0000;
    endcase
  end

  always_comb begin
    read_data = 16'h0000;
    if (req.req_type == REQ_READ) begin
      read_data = req.size_is_word ? rd_raw : {8'h00, rd_raw[7:0]};
    end
  end

  assign irq_a = (req.req_type == REQ_TICK) && tres.irq_a;
  assign irq_b = (req.req_type == REQ_TICK) && tres.irq_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r    <= 8'h00;
      mode_r       <= 8'h00;
      io_control_r <= 8'h00;
      int_enable_r <= 8'h00;
      status_r     <= STATUS_RESET;
      count_r      <= '0;
      cmp_a_r      <= COMPARE_RESET;
      cmp_b_r      <= COMPARE_RESET;
      capture_r    <= 8'h00;
      prescale_r   <= 6'd0;
    end else if (is_tick) begin
      status_r   <= tres.status;
      count_r    <= tres.count;
      prescale_r <= tres.prescale;
    end else if (is_write) begin
      unique case (req.reg_sel)
        REG_CONTROL: control_r    <= wdata[7:0];
        REG_MODE:    mode_r       <= wdata[7:0];
        REG_IO:      io_control_r <= wdata[7:0];
        REG_INT_EN:  int_enable_r <= wdata[7:0];
        REG_STATUS:  status_r     <= wdata[7:0];
        REG_COUNT:   count_r      <= count_t'(CMP_W'(wdata));
        REG_CMP_A:   cmp_a_r      <= wdata;
        REG_CMP_B:   cmp_b_r      <= wdata;
        REG_CAPTURE: capture_r    <= wdata[7:0];
        default:     ;
      endcase
    end
  end

  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (req.req_type != REQ_TICK) |-> !irq_a && !irq_b)
    else $error("interrupt raised on a non-tick beat");

  a_irq_a_sets_status: assert property (@(posedge clk) disable iff (!rst_n)
    commit && irq_a |=> status_r[0])
    else $error("compare A interrupt did not set status bit 0");

  a_cmp_a_word_write: assert property (@(posedge clk) disable iff (!rst_n)
    is_write && (req.reg_sel == REG_CMP_A) && req.size_is_word
    |=> cmp_a_r == $past(req.write_data))
    else $error("word write to compare A lost");

endmodule

// File: rtl/compare_match_timer_channel.sv
// Top level of the compare-match timer channel: input register, core and result register.
//
//   channel | handshake            | payload
//   in_     | in_valid / in_ready  | in_req_type, in_reg_sel, in_size_is_word, in_write_data
//   out_    | out_valid / out_ready| out_read_data, out_irq_a, out_irq_b
//
// Each beat is held in the input register, is resolved against the timer
// registers by one pass of logic, and its result is then captured in the result register.
// One beat is accepted per cycle when the result side keeps up.
// A stall on out_ready holds the result and the input register, and in_ready drops
// once both are full. Reset (synchronous, rst_n low) empties both stages.
module compare_match_timer_channel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_reg_sel,
  input  logic        in_size_is_word,
  input  logic [15:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_irq_a,
  output logic        out_irq_b
);
  import cmt_pkg::*;

  logic        in_valid_r;
  req_t        req_r;
  logic        out_valid_r;
  logic [15:0] read_data_r;
  logic        irq_a_r;
  logic        irq_b_r;

  logic        advance;
  logic [15:0] core_read_data;
  logic        core_irq_a;
  logic        core_irq_b;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  cmt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (advance),
    .req       (req_r),
    .read_data (core_read_data),
    .irq_a     (core_irq_a),
    .irq_b     (core_irq_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.req_type     <= in_req_type;
      req_r.reg_sel      <= in_reg_sel;
      req_r.size_is_word <= in_size_is_word;
      req_r.write_data   <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data_r <= core_read_data;
      irq_a_r     <= core_irq_a;
      irq_b_r     <= core_irq_b;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = read_data_r;
  assign out_irq_a     = irq_a_r;
  assign out_irq_b     = irq_b_r;

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready && !advance)
    else $error("input accepted while both stages are full and stalled");

endmodule

// File: verif/cmt_channel_checker.sv
// Checker for the compare-match timer channel: predicts every result beat and compares it.
module cmt_channel_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_reg_sel,
  input  logic        in_size_is_word,
  input  logic [15:0] in_write_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_read_data,
  input  logic        out_irq_a,
  input  logic        out_irq_b,
  output int          mismatches,
  output int          outstanding
);
  import cmt_pkg::*;

  typedef logic [CMP_W-1:0] wide_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_a;
    logic        irq_b;
  } timer_beat_t;

  localparam int IEN_A_BIT  = 0;
  localparam int IEN_B_BIT  = 1;
  localparam int STAT_A_BIT = 0;
  localparam int STAT_B_BIT = 1;

  logic [7:0]  ctl_q;
  logic [7:0]  mode_q;
  logic [7:0]  io_q;
  logic [7:0]  ien_q;
  logic [7:0]  stat_q;
  logic [7:0]  cap_q;
  count_t      cnt_q;
  logic [15:0] cmp_a_q;
  logic [15:0] cmp_b_q;
  logic [5:0]  pre_q;

  timer_beat_t predicted_beats[$];
  int          err_total = 0;

  function automatic logic [6:0] ticks_per_count(input logic [2:0] sel);
    if (sel == DIV_SEL_4) return 7'd4;
    if (sel == DIV_SEL_16) return 7'd16;
    if (sel == DIV_SEL_64) return 7'd64;
    return 7'd1;
  endfunction

  function automatic logic [15:0] reg_value(input logic [3:0] sel);
    wide_t c;
    c = wide_t'(cnt_q);
    case (sel)
      REG_CONTROL: return {8'h00, ctl_q};
      REG_MODE:    return {8'h00, mode_q};
      REG_IO:      return {8'h00, io_q};
      REG_INT_EN:  return {8'h00, ien_q};
      REG_STATUS:  return {8'h00, stat_q};
      REG_COUNT:   return c[15:0];
      REG_CMP_A:   return cmp_a_q;
      REG_CMP_B:   return cmp_b_q;
      REG_CAPTURE: return {8'h00, cap_q};
      default:     return 16'h0000;
    endcase
  endfunction

  // Applies one request to the shadow registers and returns the beat it should produce.
  task automatic timer_step(input logic [1:0] req, input logic [3:0] sel, input logic word,
                            input logic [15:0] data, output timer_beat_t res);
    logic [15:0] mask;
    logic [15:0] wdat;
    logic [6:0]  nxt;
    mask = word ? 16'hFFFF : 16'h00FF;
    wdat = data & mask;
    res  = '0;
    case (req)
      REQ_READ: res.read_data = reg_value(sel) & mask;
      REQ_WRITE: begin
        case (sel)
          REG_CONTROL: ctl_q = wdat[7:0];
          REG_MODE:    mode_q = wdat[7:0];
          REG_IO:      io_q = wdat[7:0];
          REG_INT_EN:  ien_q = wdat[7:0];
          REG_STATUS:  stat_q = wdat[7:0];
          REG_COUNT:   cnt_q = count_t'(wdat);
          REG_CMP_A:   cmp_a_q = wdat;
          REG_CMP_B:   cmp_b_q = wdat;
          REG_CAPTURE: cap_q = wdat[7:0];
          default: ;
        endcase
      end
      REQ_TICK: begin
        nxt = {1'b0, pre_q} + 7'd1;
        // A prescale count left above a newly chosen smaller divisor wraps at once.
        if (nxt >= ticks_per_count(ctl_q[2:0])) begin
          pre_q = '0;
          cnt_q = cnt_q + 1'b1;
        end else begin
          pre_q = nxt[5:0];
        end
        if (wide_t'(cnt_q) >= wide_t'(cmp_a_q)) begin
          if (ien_q[IEN_A_BIT]) begin
            res.irq_a = 1'b1;
            stat_q[STAT_A_BIT] = 1'b1;
          end
          if ((ctl_q & CLEAR_MODE_MASK) == CLEAR_BY_A)
            cnt_q = count_t'(wide_t'(cnt_q) - wide_t'(cmp_a_q));
        end
        // Compare B sees the counter after any pull-back by compare A.
        if (wide_t'(cnt_q) >= wide_t'(cmp_b_q)) begin
          if (ien_q[IEN_B_BIT]) begin
            res.irq_b = 1'b1;
            stat_q[STAT_B_BIT] = 1'b1;
          end
          if ((ctl_q & CLEAR_MODE_MASK) == CLEAR_BY_B)
            cnt_q = count_t'(wide_t'(cnt_q) - wide_t'(cmp_b_q));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : track
    timer_beat_t predicted;
    timer_beat_t seen;
    if (!rst_n) begin
      ctl_q   = '0;
      mode_q  = '0;
      io_q    = '0;
      ien_q   = '0;
      stat_q  = STATUS_RESET;
      cnt_q   = '0;
      cmp_a_q = COMPARE_RESET;
      cmp_b_q = COMPARE_RESET;
      cap_q   = '0;
      pre_q   = '0;
      predicted_beats.delete();
    end else begin
      if (in_valid && in_ready) begin
        timer_step(in_req_type, in_reg_sel, in_size_is_word, in_write_data, predicted);
        predicted_beats.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        seen = {out_read_data, out_irq_a, out_irq_b};
        if (predicted_beats.size() == 0) begin
          err_total++;
          $display("%0t: unexpected beat, got read_data %h irq_a %b irq_b %b",
                   $time, seen.read_data, seen.irq_a, seen.irq_b);
        end else begin
          predicted = predicted_beats.pop_front();
          if (seen.read_data !== predicted.read_data) begin
            err_total++;
            $display("%0t: read_data expected %h got %h",
                     $time, predicted.read_data, seen.read_data);
          end
          if (seen.irq_a !== predicted.irq_a) begin
            err_total++;
            $display("%0t: irq_a expected %b got %b", $time, predicted.irq_a, seen.irq_a);
          end
          if (seen.irq_b !== predicted.irq_b) begin
            err_total++;
            $display("%0t: irq_b expected %b got %b", $time, predicted.irq_b, seen.irq_b);
          end
        end
      end
    end
    mismatches  <= err_total;
    outstanding <= predicted_beats.size();
  end

endmodule

// File: verif/compare_match_timer_channel_tb.sv
// Top of the compare-match timer channel testbench: clock, reset, request stimulus and verdict.
module compare_match_timer_channel_tb;
  import cmt_pkg::*;

  localparam int         ITEMS     = 1750;
  localparam logic [1:0] REQ_NONE  = 2'd3;
  localparam logic [3:0] REG_SPARE = 4'd12;
  localparam logic [2:0] DIV_SEL_1 = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [3:0]  in_reg_sel;
  logic        in_size_is_word;
  logic [15:0] in_write_data;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_read_data;
  logic        out_irq_a;
  logic        out_irq_b;
  int          mismatches;
  int          outstanding;
  int          sent = 0;
  bit          steady = 1'b0;

  compare_match_timer_channel dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_reg_sel(in_reg_sel),
    .in_size_is_word(in_size_is_word), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_irq_a(out_irq_a), .out_irq_b(out_irq_b)
  );

  cmt_channel_checker watch (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_reg_sel(in_reg_sel),
    .in_size_is_word(in_size_is_word), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_data(out_read_data), .out_irq_a(out_irq_a), .out_irq_b(out_irq_b),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[compare_match_timer_channel] ERROR");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Small values let the counter reach a compare quickly; the rest cover the full range.
  function automatic logic [15:0] pick_compare();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'($urandom_range(1, 48));
    if (r < 53) return 16'h0000;
    if (r < 63) return COMPARE_RESET;
    return 16'($urandom());
  endfunction

  // Presents one beat and holds it until the channel takes it.
  task automatic send(input logic [1:0] req, input logic [3:0] sel, input logic word,
                      input logic [15:0] data);
    int gap;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_reg_sel      <= sel;
    in_size_is_word <= word;
    in_write_data   <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : result_side
    int run;
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 8);
      repeat (run + 1) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          next_setup;
    logic [2:0]  div_code;
    logic [2:0]  clear_code;
    logic [7:0]  ctl;
    logic [15:0] cnt;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_READ;
    in_reg_sel      <= REG_CONTROL;
    in_size_is_word <= 1'b0;
    in_write_data   <= 16'h0000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of every register, then an unmapped one.
    for (int s = 0; s <= int'(REG_CAPTURE); s++) send(REQ_READ, 4'(s), 1'b1, 16'h0000);
    send(REQ_READ, REG_SPARE, 1'b1, 16'h0000);

    // Clear on compare A at divide-by-one: the counter runs 1, 2 and falls back.
    send(REQ_WRITE, REG_INT_EN, 1'b0, 16'hFF03);
    send(REQ_WRITE, REG_CMP_A, 1'b1, 16'h0002);
    send(REQ_WRITE, REG_CONTROL, 1'b0, {8'h00, CLEAR_BY_A | 8'(DIV_SEL_1)});
    repeat (3) send(REQ_TICK, 4'($urandom()), 1'b1, 16'hFFFF);

    // A byte write to the counter keeps only the low byte.
    send(REQ_WRITE, REG_COUNT, 1'b0, 16'hABCD);
    send(REQ_READ, REG_COUNT, 1'b1, 16'h0000);

    // Shrink the divider while the prescaler already stands at the new ratio.
    send(REQ_WRITE, REG_CONTROL, 1'b1, {8'h00, 5'h00, DIV_SEL_16});
    repeat (4) send(REQ_TICK, REG_CONTROL, 1'b0, 16'h0000);
    send(REQ_WRITE, REG_CONTROL, 1'b1, {8'h00, 5'h00, DIV_SEL_4});
    send(REQ_TICK, REG_CONTROL, 1'b0, 16'h0000);
    send(REQ_READ, REG_COUNT, 1'b1, 16'h0000);
    send(REQ_WRITE, REG_SPARE, 1'b1, 16'h5A5A);
    send(REQ_NONE, REG_STATUS, 1'b1, 16'hFFFF);

    next_setup = sent;
    while (sent < ITEMS) begin
      if (sent >= next_setup) begin
        // Program a fresh timer setup, then let ticks run against it.
        r = $urandom_range(0, 99);
        clear_code = (r < 40) ? 3'(CLEAR_BY_A >> 5) : (r < 70) ? 3'(CLEAR_BY_B >> 5) :
                     3'($urandom());
        r = $urandom_range(0, 99);
        div_code = (r < 40) ? DIV_SEL_1 : (r < 60) ? DIV_SEL_4 : (r < 70) ? DIV_SEL_16 :
                   (r < 75) ? DIV_SEL_64 : 3'($urandom());
        ctl = {clear_code, 2'($urandom()), div_code};
        send(REQ_WRITE, REG_CONTROL, 1'($urandom()), {8'($urandom()), ctl});
        send(REQ_WRITE, REG_INT_EN, 1'($urandom()), 16'($urandom()));
        send(REQ_WRITE, REG_CMP_A, $urandom_range(0, 4) != 0, pick_compare());
        send(REQ_WRITE, REG_CMP_B, $urandom_range(0, 4) != 0, pick_compare());
        if ($urandom_range(0, 1) == 1) begin
          r = $urandom_range(0, 99);
          cnt = (r < 40) ? 16'($urandom_range(0, 32)) :
                (r < 60) ? 16'hFFFF - 16'($urandom_range(0, 8)) : 16'($urandom());
          send(REQ_WRITE, REG_COUNT, $urandom_range(0, 4) != 0, cnt);
        end
        if ($urandom_range(0, 3) == 0) send(REQ_WRITE, REG_STATUS, 1'($urandom()),
                                             16'($urandom()));
        steady = ($urandom_range(0, 4) == 0);
        next_setup = sent + $urandom_range(30, 120);
      end
      r = $urandom_range(0, 99);
      if (r < 60)
        send(REQ_TICK, 4'($urandom()), 1'($urandom()), 16'($urandom()));
      else if (r < 80)
        send(REQ_READ, 4'($urandom()), 1'($urandom()), 16'($urandom()));
      else if (r < 96)
        send(REQ_WRITE, 4'($urandom()), 1'($urandom()), 16'($urandom()));
      else
        send(REQ_NONE, 4'($urandom()), 1'($urandom()), 16'($urandom()));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[compare_match_timer_channel] OK");
    else
      $display("[compare_match_timer_channel] ERROR");
    $finish;
  end

endmodule
